// ===== sv/gfp_pkg.sv =====
`timescale 1ns / 1ps

package gfp_pkg;

    localparam logic [7:0] START_BYTE = 8'h3E;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
    localparam logic [1:0] STATUS_BAD_BODY   = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_LEN,
        PH_HCHK,
        PH_DATA,
        PH_BCHK
    } phase_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] command_id;
        logic [7:0] byte_index;
        logic [7:0] payload_byte;
        logic [7:0] payload_length;
        logic [1:0] status;
        logic       last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } push_t;

endpackage

// ===== sv/gfp_front.sv =====
`timescale 1ns / 1ps

module gfp_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           take,
    input  logic [7:0]     rx_byte,
    output gfp_pkg::push_t push
);

    gfp_pkg::phase_t phase_reg;
    gfp_pkg::phase_t phase_next;
    logic [7:0]      cmd_reg;
    logic [7:0]      cmd_next;
    logic [7:0]      len_reg;
    logic [7:0]      len_next;
    logic [7:0]      seen_reg;
    logic [7:0]      seen_next;
    logic [7:0]      sum_reg;
    logic [7:0]      sum_next;
    logic [7:0]      seen_inc;
    logic            hdr_ok;

    assign seen_inc = seen_reg + 8'd1;
    assign hdr_ok   = (rx_byte == (cmd_reg + len_reg));

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        seen_next  = seen_reg;
        sum_next   = sum_reg;
        if (take)
        begin
            unique case (phase_reg)
                gfp_pkg::PH_HUNT:
                begin
                    if (rx_byte == gfp_pkg::START_BYTE)
                    begin
                        phase_next = gfp_pkg::PH_CMD;
                    end
                end
                gfp_pkg::PH_CMD:
                begin
                    cmd_next   = rx_byte;
                    phase_next = gfp_pkg::PH_LEN;
                end
                gfp_pkg::PH_LEN:
                begin
                    len_next   = rx_byte;
                    phase_next = gfp_pkg::PH_HCHK;
                end
                gfp_pkg::PH_HCHK:
                begin
                    if (!hdr_ok)
                    begin
                        phase_next = gfp_pkg::PH_HUNT;
                    end
                    else
                    begin
                        seen_next  = 8'd0;
                        sum_next   = 8'd0;
                        phase_next = (len_reg == 8'd0) ? gfp_pkg::PH_BCHK
                                                       : gfp_pkg::PH_DATA;
                    end
                end
                gfp_pkg::PH_DATA:
                begin
                    sum_next  = sum_reg + rx_byte;
                    seen_next = seen_inc;
                    if (seen_inc == len_reg)
                    begin
                        phase_next = gfp_pkg::PH_BCHK;
                    end
                end
                gfp_pkg::PH_BCHK:
                begin
                    phase_next = gfp_pkg::PH_HUNT;
                end
                default:
                begin
                    phase_next = gfp_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // result for the accepted beat
    always_comb
    begin
        push.valid               = 1'b0;
        push.data.kind           = gfp_pkg::KIND_STATUS;
        push.data.command_id     = cmd_reg;
        push.data.byte_index     = 8'd0;
        push.data.payload_byte   = 8'd0;
        push.data.payload_length = len_reg;
        push.data.status         = gfp_pkg::STATUS_OK;
        push.data.last           = 1'b1;
        unique case (phase_reg)
            gfp_pkg::PH_HCHK:
            begin
                push.valid       = take && !hdr_ok;
                push.data.status = gfp_pkg::STATUS_BAD_HEADER;
            end
            gfp_pkg::PH_DATA:
            begin
                push.valid             = take;
                push.data.kind         = gfp_pkg::KIND_PAYLOAD;
                push.data.byte_index   = seen_reg;
                push.data.payload_byte = rx_byte;
                push.data.last         = 1'b0;
            end
            gfp_pkg::PH_BCHK:
            begin
                push.valid       = take;
                push.data.status = (rx_byte == sum_reg) ? gfp_pkg::STATUS_OK
                                                        : gfp_pkg::STATUS_BAD_BODY;
            end
            default:
            begin
                push.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gfp_pkg::PH_HUNT;
            cmd_reg   <= 8'd0;
            len_reg   <= 8'd0;
            seen_reg  <= 8'd0;
            sum_reg   <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

// ===== sv/gfp_queue.sv =====
`timescale 1ns / 1ps

module gfp_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  gfp_pkg::push_t   push,
    input  logic             pop,
    output logic             full,
    output logic             q_valid,
    output gfp_pkg::result_t q_data
);

    gfp_pkg::result_t            mem_reg [gfp_pkg::QUEUE_DEPTH];
    logic [gfp_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [gfp_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [gfp_pkg::QUEUE_AW:0]   count_reg;
    logic [gfp_pkg::QUEUE_AW:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full    = (count_reg == (gfp_pkg::QUEUE_AW + 1)'(gfp_pkg::QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign do_push = push.valid && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push.data;
        end
    end

endmodule

// ===== sv/gfp_back.sv =====
`timescale 1ns / 1ps

module gfp_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  gfp_pkg::result_t q_data,
    output logic             pop,
    input  logic             out_stall,
    output logic             out_valid,
    output gfp_pkg::result_t out_data
);

    logic             valid_reg;
    logic             valid_next;
    gfp_pkg::result_t data_reg;

    assign pop        = q_valid && (!valid_reg || !out_stall);
    assign valid_next = pop ? 1'b1 : (valid_reg && out_stall);
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= q_data;
        end
    end

endmodule

// ===== sv/gimbal_frame_parser_unit.sv =====
`timescale 1ns / 1ps

// Frame parser for a serial byte stream: '>' start, command id, length, header
// sum, payload, body sum. One byte is taken per cycle unless the queue is full; a
// parser state machine classifies each byte and pushes any result into a
// four-entry queue, and an output register delivers results, so in_stall rises
// only when that queue is full. Payload bytes leave as they arrive; each frame
// closes with one status beat (last high), and a frame whose status is not ok
// must be dropped by the consumer.

module gimbal_frame_parser_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic [7:0] command_id,
    output logic [7:0] byte_index,
    output logic [7:0] payload_byte,
    output logic [7:0] payload_length,
    output logic [1:0] status,
    output logic       last
);

    gfp_pkg::push_t   push;
    gfp_pkg::result_t q_data;
    gfp_pkg::result_t out_data;
    logic             q_valid;
    logic             q_full;
    logic             pop;
    logic             take;

    assign in_stall = q_full;
    assign take     = in_valid && !q_full;

    gfp_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .push    (push)
    );

    gfp_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .pop     (pop),
        .full    (q_full),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    gfp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign kind           = out_data.kind;
    assign command_id     = out_data.command_id;
    assign byte_index     = out_data.byte_index;
    assign payload_byte   = out_data.payload_byte;
    assign payload_length = out_data.payload_length;
    assign status         = out_data.status;
    assign last           = out_data.last;

endmodule

// ===== dv/tb_gimbal_frame_parser_unit.sv =====
`timescale 1ns / 1ps

module tb_gimbal_frame_parser_unit;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    class frame_scoreboard;
        gfp_pkg::phase_t  phase;
        logic [7:0]       held_command;
        logic [7:0]       held_length;
        logic [7:0]       bytes_seen;
        logic [7:0]       running_sum;
        gfp_pkg::result_t expected_beats[$];
        int               errors;
        int               framed_bytes;
        int               beats_checked;
        int               frames_closed;

        function new();
            phase = gfp_pkg::PH_HUNT;
            held_command = '0;
            held_length = '0;
            bytes_seen = '0;
            running_sum = '0;
            errors = 0;
            framed_bytes = 0;
            beats_checked = 0;
            frames_closed = 0;
        endfunction

        function void note_byte(logic [7:0] b);
            gfp_pkg::result_t r;
            logic [7:0]       header_sum;
            r = '0;
            header_sum = held_command + held_length;
            if (phase != gfp_pkg::PH_HUNT || b == gfp_pkg::START_BYTE)
                framed_bytes++;
            case (phase)
                gfp_pkg::PH_CMD:
                begin
                    held_command = b;
                    phase = gfp_pkg::PH_LEN;
                end
                gfp_pkg::PH_LEN:
                begin
                    held_length = b;
                    phase = gfp_pkg::PH_HCHK;
                end
                gfp_pkg::PH_HCHK:
                begin
                    if (b != header_sum)
                    begin
                        r.kind = gfp_pkg::KIND_STATUS;
                        r.command_id = held_command;
                        r.payload_length = held_length;
                        r.status = gfp_pkg::STATUS_BAD_HEADER;
                        r.last = 1'b1;
                        expected_beats.push_back(r);
                        phase = gfp_pkg::PH_HUNT;
                    end
                    else
                    begin
                        bytes_seen = '0;
                        running_sum = '0;
                        phase = (held_length == 8'd0) ? gfp_pkg::PH_BCHK
                                                      : gfp_pkg::PH_DATA;
                    end
                end
                gfp_pkg::PH_DATA:
                begin
                    r.kind = gfp_pkg::KIND_PAYLOAD;
                    r.command_id = held_command;
                    r.byte_index = bytes_seen;
                    r.payload_byte = b;
                    r.payload_length = held_length;
                    r.status = gfp_pkg::STATUS_OK;
                    r.last = 1'b0;
                    expected_beats.push_back(r);
                    running_sum = running_sum + b;
                    bytes_seen = bytes_seen + 8'd1;
                    if (bytes_seen == held_length)
                        phase = gfp_pkg::PH_BCHK;
                end
                gfp_pkg::PH_BCHK:
                begin
                    r.kind = gfp_pkg::KIND_STATUS;
                    r.command_id = held_command;
                    r.payload_length = held_length;
                    r.status = (b == running_sum) ? gfp_pkg::STATUS_OK
                                                  : gfp_pkg::STATUS_BAD_BODY;
                    r.last = 1'b1;
                    expected_beats.push_back(r);
                    phase = gfp_pkg::PH_HUNT;
                end
                default:
                    phase = (b == gfp_pkg::START_BYTE) ? gfp_pkg::PH_CMD
                                                       : gfp_pkg::PH_HUNT;
            endcase
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got)
            begin
                $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(gfp_pkg::result_t got);
            gfp_pkg::result_t want;
            if (expected_beats.size() == 0)
            begin
                $error("result beat with nothing expected: 0x%0h", got);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            beats_checked++;
            if (got.last)
                frames_closed++;
            compare_field("kind", want.kind, got.kind);
            compare_field("command_id", want.command_id, got.command_id);
            compare_field("byte_index", want.byte_index, got.byte_index);
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("payload_length", want.payload_length, got.payload_length);
            compare_field("status", want.status, got.status);
            compare_field("last", want.last, got.last);
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic       kind;
    logic [7:0] command_id;
    logic [7:0] byte_index;
    logic [7:0] payload_byte;
    logic [7:0] payload_length;
    logic [1:0] status;
    logic       last;

    int in_idle_pct = 37;
    int out_stall_pct = 78;
    int cycle_count = 0;

    frame_scoreboard sb;

    // noise, empty frame, rejected header, start byte as command, wrapped
    // header sum with start byte as payload and bad body sum
    logic [7:0] opening_bytes [24] = '{
        8'h00, 8'hFF,
        gfp_pkg::START_BYTE, 8'h00, 8'h00, 8'h00, 8'h00,
        gfp_pkg::START_BYTE, 8'h12, 8'h34, 8'h00,
        gfp_pkg::START_BYTE, gfp_pkg::START_BYTE, 8'h02, 8'h40, 8'h00, 8'hFF, 8'hFF,
        gfp_pkg::START_BYTE, 8'hFF, 8'h01, 8'h00, gfp_pkg::START_BYTE, 8'h00
    };

    gimbal_frame_parser_unit uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .command_id     (command_id),
        .byte_index     (byte_index),
        .payload_byte   (payload_byte),
        .payload_length (payload_length),
        .status         (status),
        .last           (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < out_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({kind, command_id, byte_index, payload_byte,
                             payload_length, status, last});
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $error("watchdog expired after %0d cycles", cycle_count);
        $display("== FAIL ==");
        $finish;
    end

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b);
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len,
                              input bit hdr_bad, input bit body_bad);
        logic [7:0] sum;
        logic [7:0] b;
        sum = cmd + len;
        if (hdr_bad)
            sum = sum + 8'($urandom_range(1, 255));
        send_byte(gfp_pkg::START_BYTE);
        send_byte(cmd);
        send_byte(len);
        send_byte(sum);
        if (hdr_bad)
            return;
        sum = '0;
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(255));
            sum = sum + b;
            send_byte(b);
        end
        if (body_bad)
            sum = sum + 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    task automatic send_random_traffic(input int target);
        int         start;
        int         pick;
        logic [7:0] len;
        start = sb.framed_bytes;
        while (sb.framed_bytes - start < target)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_byte(8'($urandom_range(255)));
            else if (pick < 14)
            begin
                // truncated frame, the next bytes get swallowed into it
                send_byte(gfp_pkg::START_BYTE);
                repeat ($urandom_range(1, 3))
                    send_byte(8'($urandom_range(255)));
            end
            else
            begin
                len = ($urandom_range(9) < 7) ? 8'($urandom_range(6))
                                              : 8'($urandom_range(7, 24));
                send_frame(8'($urandom_range(255)), len,
                           $urandom_range(9) == 0, $urandom_range(7) == 0);
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (opening_bytes[i])
            send_byte(opening_bytes[i]);
        send_random_traffic(200);

        in_idle_pct = 78;
        out_stall_pct = 37;
        send_random_traffic(200);

        in_idle_pct = 0;
        out_stall_pct = 0;
        send_frame(8'($urandom_range(255)), 8'd255, 1'b0, 1'b0);
        send_random_traffic(200);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d framed input bytes and %0d result beats over %0d frames,",
                 sb.framed_bytes, sb.beats_checked, sb.frames_closed);
        $display("with sender and receiver idling in turn and a full-length payload");
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
